@@ src/ssir_pkg.sv @@
// Shared definitions for the set store core: request and status codes,
// the per-cell control bundle and the default capacity. No dependencies.
`timescale 1ns / 1ps

package ssir_pkg;

	localparam int DefCapacity = 64;

	localparam int ValueW  = 32;
	localparam int ReqW    = 2;
	localparam int StatusW = 3;
	localparam int OutCntW = 7;

	// Request codes carried in the request kind field.
	localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [ReqW-1:0] REQ_INSERT = 2'd1;
	localparam logic [ReqW-1:0] REQ_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [StatusW-1:0] ST_DONE      = 3'd0;
	localparam logic [StatusW-1:0] ST_PRESENT   = 3'd1;
	localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [StatusW-1:0] ST_EMPTY     = 3'd3;
	localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

	// Commands broadcast to every cell of the chain in the execute cycle.
	typedef struct packed {
		logic ins_en;  // append the key at the slot equal to the count
		logic rem_en;  // cells at or past the hit take their upper neighbour
	} cell_ctrl_t;

endpackage

@@ src/ssir_cell.sv @@
// One slot of the set store chain: holds a value, compares it with the key
// and takes the key or its upper neighbour's value on command. Uses ssir_pkg.
`timescale 1ns / 1ps

module ssir_cell #(
	parameter int Idx    = 0,
	parameter int CountW = 7
) (
	input  logic                            clk,
	input  ssir_pkg::cell_ctrl_t            ctrl,
	input  logic [ssir_pkg::ValueW-1:0]     key,
	input  logic [CountW-1:0]               count,
	input  logic                            hit_before,
	input  logic [ssir_pkg::ValueW-1:0]     next_data,
	output logic [ssir_pkg::ValueW-1:0]     data,
	output logic                            match
);

	logic [ssir_pkg::ValueW-1:0] data_q;
	logic                        occupied;
	logic                        at_tail;

	assign occupied = count > CountW'(Idx);
	assign at_tail  = count == CountW'(Idx);
	assign match    = occupied && (data_q == key);
	assign data     = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && at_tail) begin
			data_q <= key;
		end else if (ctrl.rem_en && hit_before) begin
			data_q <= next_data;
		end
	end

endmodule

@@ src/ssir_prefix.sv @@
// Parallel prefix OR over the cell match lines: bit i is set when any cell
// at or below slot i holds the key. Log-depth tree, no package dependency.
`timescale 1ns / 1ps

module ssir_prefix #(
	parameter int N = 64
) (
	input  logic [N-1:0] hits,
	output logic [N-1:0] prefix
);

	localparam int Levels = (N > 1) ? $clog2(N) : 1;

	// Running result of the levels built so far, and the level being built.
	logic [N-1:0] acc;
	logic [N-1:0] nxt;

	// Each level ORs every bit with the bit a power of two below it, so after
	// the last level every bit covers all bits beneath it.
	always_comb begin
		acc = hits;
		nxt = hits;
		for (int l = 0; l < Levels; l++) begin
			nxt = acc;
			for (int i = 0; i < N; i++) begin
				if (i >= (1 << l)) begin
					nxt[i] = acc[i] | acc[i - (1 << l)];
				end
			end
			acc = nxt;
		end
	end

	assign prefix = acc;

endmodule

@@ src/set_store_insert_remove_core.sv @@
// Top level of the set store core: request handshake, count register,
// chain of slot cells and result register. Uses ssir_pkg, ssir_cell, ssir_prefix.
`timescale 1ns / 1ps

// The core keeps a set of distinct 32-bit values packed in a chain of
// CAPACITY slot cells, with a count of the slots in use. Each request
// transfer (clear, insert or remove, selected by s_tuser) produces exactly
// one result transfer carrying a status, the count after the request and
// an empty flag. A request is first registered; then, in the execute cycle,
// every cell compares its value with the key at once, a prefix tree
// locates the hit and the whole chain is updated. Removal closes the gap
// in that same cycle, each cell at or above the hit taking its upper
// neighbour's value. No new request is taken while one is in execution;
// the result register lets the next request be taken in the very cycle
// the previous result is transferred. Slot contents are not cleared at
// reset; only slots below the count are ever compared.
module set_store_insert_remove_core #(
	parameter int CAPACITY = ssir_pkg::DefCapacity
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request side.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// Result side.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] status, [9:3] member_count,
	                               // [10] set_is_empty, [15:11] zero
);

	localparam int CountW = $clog2(CAPACITY + 1);

	// Registered request, held for the execute cycle.
	logic                             busy_q;
	logic [ssir_pkg::ReqW-1:0]        req_q;
	logic [ssir_pkg::ValueW-1:0]      key_q;

	logic [CountW-1:0]                count_q;
	logic [CountW-1:0]                count_nx;
	logic [ssir_pkg::StatusW-1:0]     status_nx;

	logic                             m_tvalid_q;
	logic [15:0]                      m_tdata_q;

	ssir_pkg::cell_ctrl_t             ctrl;
	logic [CAPACITY-1:0]              hits;
	logic [CAPACITY-1:0]              hit_before;
	logic [ssir_pkg::ValueW-1:0]      slot_data [CAPACITY];
	logic                             found;
	logic                             full;
	logic                             accept;
	logic [CountW+ssir_pkg::OutCntW-1:0] count_ext;

	// A request is taken when nothing is in execution and the result
	// register is free by the time the execute cycle loads it.
	assign s_tready = !busy_q && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_tuser;
			key_q <= s_tdata;
		end
	end

	// The chain of slot cells. The top cell has no upper neighbour and
	// simply keeps its own value when a removal shifts through it.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ssir_pkg::ValueW-1:0] upper;
		if (i == CAPACITY - 1) begin : g_top
			assign upper = slot_data[i];
		end else begin : g_mid
			assign upper = slot_data[i+1];
		end
		ssir_cell #(
			.Idx    (i),
			.CountW (CountW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.key        (key_q),
			.count      (count_q),
			.hit_before (hit_before[i]),
			.next_data  (upper),
			.data       (slot_data[i]),
			.match      (hits[i])
		);
	end

	ssir_prefix #(
		.N (CAPACITY)
	) u_prefix (
		.hits   (hits),
		.prefix (hit_before)
	);

	// Values are distinct, so at most one cell matches; the last prefix bit
	// tells whether the key is present at all.
	assign found = hit_before[CAPACITY-1];
	assign full  = count_q == CountW'(CAPACITY);

	// Decision for the request in execution.
	always_comb begin
		count_nx    = count_q;
		status_nx   = ssir_pkg::ST_DONE;
		ctrl.ins_en = 1'b0;
		ctrl.rem_en = 1'b0;
		unique case (req_q)
			ssir_pkg::REQ_CLEAR: begin
				count_nx = '0;
			end
			ssir_pkg::REQ_INSERT: begin
				if (found) begin
					status_nx = ssir_pkg::ST_PRESENT;
				end else if (full) begin
					status_nx = ssir_pkg::ST_FULL;
				end else begin
					ctrl.ins_en = busy_q;
					count_nx    = count_q + CountW'(1);
				end
			end
			ssir_pkg::REQ_REMOVE: begin
				if (count_q == '0) begin
					status_nx = ssir_pkg::ST_EMPTY;
				end else if (!found) begin
					status_nx = ssir_pkg::ST_NOT_FOUND;
				end else begin
					ctrl.rem_en = busy_q;
					count_nx    = count_q - CountW'(1);
				end
			end
			default: begin
				// The unused request code leaves the set untouched.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (busy_q) begin
			count_q <= count_nx;
		end
	end

	// The reported count is the low seven bits of the count.
	assign count_ext = {{ssir_pkg::OutCntW{1'b0}}, count_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (busy_q) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			m_tdata_q <= {5'b0, (count_nx == '0), count_ext[ssir_pkg::OutCntW-1:0],
				status_nx};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ dv/set_store_checker.sv @@
// Checker for the set store core: watches the request and result streams,
// keeps its own copy of the set and compares every result transfer field by field.
// Depends on ssir_pkg for the request and status codes and the field widths.
`timescale 1ns / 1ps

module set_store_checker
	import ssir_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [2:0] status, [9:3] member_count, [10] set_is_empty
	output int          error_count,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [OutCntW-1:0] count;
		logic               empty;
	} outcome_t;

	// Shadow of the set: packed entries below members_held are valid.
	logic [ValueW-1:0] member_values [CAPACITY];
	int unsigned       members_held;
	outcome_t          awaited_outcomes [$];

	// Applies one request to the shadow set and returns the result it should give.
	function automatic outcome_t apply_request(input logic [ReqW-1:0] kind,
	                                           input logic [ValueW-1:0] key);
		outcome_t    res;
		int unsigned hit;
		int unsigned i;
		res.status = ST_DONE;
		hit = members_held;
		for (i = 0; i < members_held; i++) begin
			if (member_values[i] == key && hit == members_held) begin
				hit = i;
			end
		end
		case (kind)
			REQ_CLEAR: begin
				members_held = 0;
			end
			REQ_INSERT: begin
				if (hit < members_held) begin
					res.status = ST_PRESENT;
				end else if (members_held >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					member_values[members_held] = key;
					members_held++;
				end
			end
			REQ_REMOVE: begin
				if (members_held == 0) begin
					res.status = ST_EMPTY;
				end else if (hit >= members_held) begin
					res.status = ST_NOT_FOUND;
				end else begin
					// Close the gap left by the removed entry.
					for (i = hit; i + 1 < members_held; i++) begin
						member_values[i] = member_values[i + 1];
					end
					members_held--;
				end
			end
			default: begin
			end
		endcase
		res.count = OutCntW'(members_held);
		res.empty = (members_held == 0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t seen;
		outcome_t want;
		if (!arst_n) begin
			members_held = 0;
			awaited_outcomes.delete();
		end else begin
			// A result cannot leave in the cycle its request arrives, so the
			// result side is checked before the new request is predicted.
			if (m_tvalid && m_tready) begin
				seen.status = m_tdata[2:0];
				seen.count  = m_tdata[9:3];
				seen.empty  = m_tdata[10];
				if (awaited_outcomes.size() == 0) begin
					$error("unexpected result transfer, tdata %h", m_tdata);
					error_count++;
				end else begin
					want = awaited_outcomes.pop_front();
					checked++;
					if (seen.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, seen.status);
						error_count++;
					end
					if (seen.count !== want.count) begin
						$error("member_count: expected %0d, actual %0d", want.count, seen.count);
						error_count++;
					end
					if (seen.empty !== want.empty) begin
						$error("set_is_empty: expected %0d, actual %0d", want.empty, seen.empty);
						error_count++;
					end
					if (m_tdata[15:11] !== 5'd0) begin
						$error("padding: expected 0, actual %h", m_tdata[15:11]);
						error_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				awaited_outcomes.push_back(apply_request(s_tuser, s_tdata));
			end
		end
		pending = awaited_outcomes.size();
	end

endmodule

@@ dv/testbench.sv @@
// Top of the set store core testbench: clock, reset, request stimulus,
// result-side back-pressure and the final verdict.
// Depends on ssir_pkg, set_store_insert_remove_core and set_store_checker.
`timescale 1ns / 1ps

module testbench;
	import ssir_pkg::*;

	localparam int CAPACITY     = DefCapacity;
	localparam int RANDOM_ITEMS = 700;
	localparam int POOL_SIZE    = 96;
	localparam int DRAIN_LIMIT  = 20000;

	// The request kind field is two bits wide; the fourth code is unassigned
	// and must leave the set untouched.
	localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PATTERN
	} ready_mode_t;

	typedef enum int {
		EP_FILL,
		EP_CHURN,
		EP_DRAIN,
		EP_NOISE
	} episode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [2:0] status, [9:3] member_count, [10] set_is_empty

	int error_count;
	int pending;
	int checked;

	set_store_insert_remove_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	set_store_checker #(
		.CAPACITY(CAPACITY)
	) checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.error_count(error_count),
		.pending    (pending),
		.checked    (checked)
	);

	// 12 ns period: six nanoseconds low, six high.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop in case the handshakes lock up somewhere.
	initial begin
		#5000000;
		$display("FAIL set_store_insert_remove_core");
		$finish;
	end

	// Result-side back-pressure. The receiver switches every so often between
	// always ready, a coin toss, mostly stalled and a fixed repeating pattern,
	// so that stalls fall on every phase of the core's operation and there are
	// also long stretches with no stall at all.
	ready_mode_t ready_mode = READY_ALWAYS;
	int          ready_left = 0;
	int          ready_phase = 0;

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_left = $urandom_range(20, 200);
		end else begin
			ready_left--;
		end
		ready_phase = (ready_phase + 1) % 7;
		case (ready_mode)
			READY_ALWAYS:  m_tready <= 1'b1;
			READY_COIN:    m_tready <= 1'($urandom_range(0, 1));
			READY_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
			default:       m_tready <= (ready_phase < 3);
		endcase
	end

	// Sender state: requests go out in bursts of random length; a burst ends
	// with a random gap unless the current episode runs without gaps.
	int burst_left = 0;
	bit steady = 1'b0;
	int n_clear = 0;
	int n_insert = 0;
	int n_remove = 0;
	int n_unused = 0;

	logic [31:0] value_pool [POOL_SIZE];

	// Offers one request and returns at the falling edge after its transfer.
	// The valid is lowered only when a gap is actually inserted, so a valid
	// that stays high between back-to-back requests is never dropped and raised
	// again in the same time step.
	task automatic send_request(input logic [ReqW-1:0] kind, input logic [ValueW-1:0] key);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		case (kind)
			REQ_CLEAR:  n_clear++;
			REQ_INSERT: n_insert++;
			REQ_REMOVE: n_remove++;
			default:    n_unused++;
		endcase
	endtask

	// Holds the request side idle until every outstanding result has come back.
	task automatic wait_until_settled();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// Narrow picks come from the first sixteen pool entries, so inserts and
	// removes keep colliding with what is held; wide picks spread over the pool.
	function automatic logic [ValueW-1:0] pick_value(input bit narrow);
		return value_pool[$urandom_range(0, narrow ? 15 : POOL_SIZE - 1)];
	endfunction

	initial begin
		int       base_items;
		int       len;
		int       start;
		int       waited;
		bit       narrow;
		bit       first_episode;
		episode_t episode;
		logic [ReqW-1:0] kind;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = REQ_CLEAR;
		s_tdata  = '0;

		// The pool holds the extremes, a run of values one bit apart (so that
		// a compare that ignores a bit would merge them) and random values.
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		value_pool[4] = $urandom;
		for (int k = 5; k < 12; k++) begin
			value_pool[k] = value_pool[4] ^ (32'd1 << $urandom_range(0, 31));
		end
		for (int k = 12; k < POOL_SIZE; k++) begin
			value_pool[k] = $urandom;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: an empty store, the signed extremes, values that
		// differ in one bit only, removal from the head, middle and tail of the
		// packed array, the unused request code and clears.
		steady = 1'b1;
		send_request(REQ_REMOVE, 32'h0000_0005);   // set was empty
		send_request(REQ_INSERT, 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 32'h8000_0000);
		send_request(REQ_INSERT, 32'h0000_0000);
		send_request(REQ_INSERT, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 32'h8000_0000);   // already present
		send_request(REQ_INSERT, 32'h7FFF_FFFE);   // one bit from a held value
		send_request(REQ_REMOVE, 32'h0000_0001);   // not found
		send_request(REQ_REMOVE, 32'h8000_0000);   // middle, later entries shift
		send_request(REQ_REMOVE, 32'h7FFF_FFFF);   // head
		send_request(REQ_REMOVE, 32'h7FFF_FFFE);   // tail
		send_request(REQ_UNUSED, 32'hA5A5_A5A5);
		send_request(REQ_INSERT, 32'h8000_0000);   // back in after removal
		send_request(REQ_CLEAR,  32'hFFFF_FFFF);
		send_request(REQ_UNUSED, 32'h5A5A_5A5A);
		send_request(REQ_REMOVE, 32'h0000_0000);   // empty after the clear
		send_request(REQ_CLEAR,  32'h0000_0000);   // clear of an empty set
		send_request(REQ_INSERT, 32'h5555_5555);
		send_request(REQ_INSERT, 32'hAAAA_AAAA);
		send_request(REQ_REMOVE, 32'h5555_5555);
		send_request(REQ_REMOVE, 32'hAAAA_AAAA);   // count drops to zero
		send_request(REQ_REMOVE, 32'hAAAA_AAAA);   // empty again

		// Let the pipeline drain completely once before the random part.
		wait_until_settled();

		// Random part, in episodes. Fill episodes walk through consecutive pool
		// entries so the store reaches capacity and then refuses further
		// inserts; the very first episode is a fill from an empty set.
		base_items = n_clear + n_insert + n_remove;
		first_episode = 1'b1;
		while (n_clear + n_insert + n_remove < base_items + RANDOM_ITEMS) begin
			episode = first_episode ? EP_FILL : episode_t'($urandom_range(0, 3));
			steady = ($urandom_range(0, 3) == 0);
			narrow = 1'($urandom_range(0, 1));
			case (episode)
				EP_FILL: begin
					if (first_episode || $urandom_range(0, 1)) begin
						send_request(REQ_CLEAR, $urandom);
					end
					start = $urandom_range(0, POOL_SIZE - 1);
					len = $urandom_range(CAPACITY, CAPACITY + 8);
					for (int k = 0; k < len; k++) begin
						send_request(REQ_INSERT, value_pool[(start + k) % POOL_SIZE]);
					end
					repeat ($urandom_range(2, 10)) begin
						send_request(REQ_REMOVE,
							value_pool[(start + $urandom_range(0, len - 1)) % POOL_SIZE]);
					end
				end
				EP_CHURN: begin
					len = $urandom_range(30, 80);
					repeat (len) begin
						case ($urandom_range(0, 39)) inside
							[0:0]:   send_request(REQ_CLEAR, $urandom);
							[1:21]:  send_request(REQ_INSERT, pick_value(narrow));
							default: send_request(REQ_REMOVE, pick_value(narrow));
						endcase
					end
				end
				EP_DRAIN: begin
					len = $urandom_range(20, 60);
					repeat (len) begin
						if ($urandom_range(0, 19) < 17) begin
							send_request(REQ_REMOVE, pick_value(narrow));
						end else begin
							send_request(REQ_INSERT, pick_value(narrow));
						end
					end
				end
				default: begin
					// Noise: any code and any value, clears kept rare so the set
					// is not emptied at every turn.
					len = $urandom_range(5, 15);
					repeat (len) begin
						kind = ReqW'($urandom_range(0, 3));
						if (kind == REQ_CLEAR && $urandom_range(0, 3) != 0) begin
							kind = REQ_UNUSED;
						end
						send_request(kind, $urandom);
					end
				end
			endcase
			first_episode = 1'b0;
			if ($urandom_range(0, 7) == 0) begin
				wait_until_settled();
			end
		end

		// All stimulus is in; wait for the outstanding results, then give the
		// core a few more cycles in case a stray result follows.
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending != 0) begin
			$display("FAIL set_store_insert_remove_core");
			$finish;
		end else begin
			repeat (8) @(negedge clk);
			$display("Requests sent: %0d clear, %0d insert, %0d remove, %0d unused code.",
				n_clear, n_insert, n_remove, n_unused);
			$display("Results compared: %0d, mismatches: %0d.", checked, error_count);
			if (error_count == 0 && pending == 0) begin
				$display("PASS set_store_insert_remove_core");
			end else begin
				$display("FAIL set_store_insert_remove_core");
			end
			$finish;
		end
	end

endmodule
